### sv/sequential_char_run_contractor_top_assert.svh
// Assertion macros for the run contractor checker.
`ifndef SEQUENTIAL_CHAR_RUN_CONTRACTOR_TOP_ASSERT_SVH
`define SEQUENTIAL_CHAR_RUN_CONTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrc check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off during reset.
`define SCRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrc check failed: next-cycle rule");

`endif

### sv/scrc_pkg.sv
`default_nettype none

package scrc_pkg;

    localparam int unsigned MAX_RESULTS   = 6;
    localparam logic [7:0]  DASH_CHAR     = 8'h2D;
    localparam logic [1:0]  MIN_RUN_RESET = 2'd3;

    // pending byte and run tracking
    typedef struct packed {
        logic [7:0] pending_char;
        logic       pending_valid;
        logic [7:0] run_first_char;
        logic [1:0] run_pairs;
    } state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
        logic       string_done;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] result_vec_t;

endpackage

`default_nettype wire

### sv/scrc_in_if.sv
`default_nettype none

interface scrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_string;

    modport source (output valid, output ch, output end_of_string, input ready);
    modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

`default_nettype wire

### sv/scrc_out_if.sv
`default_nettype none

interface scrc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       string_done;

    modport source (output valid, output out_char, output last_of_run,
                    output string_done, input ready);
    modport sink   (input valid, input out_char, input last_of_run,
                    input string_done, output ready);
endinterface

`default_nettype wire

### sv/scrc_step.sv
`default_nettype none

// One item's worth of run tracking: judge the held byte, then the final byte.
module scrc_step
    import scrc_pkg::*;
(
    input  state_t      st,
    input  logic [7:0]  ch,
    input  logic        end_of_string,
    input  logic [1:0]  min_run,
    output state_t      st_next,
    output result_vec_t res,
    output logic [2:0]  res_cnt
);

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_LOWER = 2'd1;
    localparam logic [1:0] CLS_UPPER = 2'd2;
    localparam logic [1:0] CLS_DIGIT = 2'd3;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      cnt;
        logic [7:0]      first;
        logic [1:0]      pairs;
    } judge_t;

    function automatic logic [1:0] char_class(input logic [7:0] c);
        logic [1:0] k;
        k = CLS_NONE;
        if (c >= 8'h61 && c <= 8'h7A)
            k = CLS_LOWER;
        else if (c >= 8'h41 && c <= 8'h5A)
            k = CLS_UPPER;
        else if (c >= 8'h30 && c <= 8'h39)
            k = CLS_DIGIT;
        return k;
    endfunction

    function automatic logic is_successor(input logic [7:0] cur, input logic [7:0] nxt);
        logic [1:0] k;
        k = char_class(cur);
        return (k != CLS_NONE) && (k == char_class(nxt))
            && ({1'b0, nxt} == ({1'b0, cur} + 9'd1));
    endfunction

    function automatic judge_t judge(input logic [7:0] cur, input logic seq,
                                     input logic [7:0] first, input logic [1:0] pairs,
                                     input logic [1:0] limit_m1);
        judge_t j;
        j.b     = '0;
        j.cnt   = 2'd0;
        j.first = first;
        j.pairs = pairs;
        if (seq)
        begin
            if (pairs == 2'd0)
            begin
                j.first = cur;
                j.pairs = 2'd1;
            end
            else if (pairs < 2'd2)
            begin
                j.pairs = pairs + 2'd1;
            end
        end
        else
        begin
            if (pairs != 2'd0 && pairs >= limit_m1)
            begin
                j.b[0] = first;
                j.b[1] = DASH_CHAR;
                j.b[2] = cur;
                j.cnt  = 2'd3;
            end
            else if (pairs != 2'd0)
            begin
                j.b[0] = first;
                j.b[1] = cur;
                j.cnt  = 2'd2;
            end
            else
            begin
                j.b[0] = cur;
                j.cnt  = 2'd1;
            end
            j.pairs = 2'd0;
        end
        return j;
    endfunction

    logic [1:0] limit_m1;
    judge_t     j_held;
    judge_t     j_final;
    logic [2:0] final_cnt;
    logic [2:0] idx;

    always_comb
    begin
        // min_run below two acts as two
        limit_m1 = (min_run < 2'd2) ? 2'd1 : (min_run - 2'd1);

        if (st.pending_valid)
            j_held = judge(st.pending_char, is_successor(st.pending_char, ch),
                           st.run_first_char, st.run_pairs, limit_m1);
        else
        begin
            j_held       = '0;
            j_held.first = st.run_first_char;
            j_held.pairs = st.run_pairs;
        end

        // final byte is judged against the terminator, never a successor
        j_final   = judge(ch, 1'b0, j_held.first, j_held.pairs, limit_m1);
        final_cnt = end_of_string ? {1'b0, j_final.cnt} : 3'd0;
        res_cnt   = {1'b0, j_held.cnt} + final_cnt;

        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(j_held.cnt))
                res[i].out_char = j_held.b[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            idx = {1'b0, j_held.cnt} + 3'(i);
            if (i < int'(final_cnt))
                res[idx].out_char = j_final.b[i];
        end
        if (res_cnt != 3'd0)
        begin
            res[res_cnt - 3'd1].last_of_run = 1'b1;
            res[res_cnt - 3'd1].string_done = end_of_string;
        end

        if (end_of_string)
            st_next = '0;
        else
        begin
            st_next.pending_char   = ch;
            st_next.pending_valid  = 1'b1;
            st_next.run_first_char = j_held.first;
            st_next.run_pairs      = j_held.pairs;
        end
    end

endmodule

`default_nettype wire

### sv/sequential_char_run_contractor_top.sv
// Path: an accepted item is held in the input register stage, and its result bytes are
// then loaded into the result burst register, whose slot 0 drives dout.
// Throughput: one item per cycle while each item yields at most one result byte and
// dout takes them; an item that yields more bytes (up to six) holds intake until
// the result burst register has passed them all to dout.
// Reset (rst_n low, asynchronous): no item held, run state cleared, min_run back to 3.
`default_nettype none

module sequential_char_run_contractor_top
    import scrc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    scrc_in_if.sink    din,
    scrc_out_if.source dout,
    input  wire        cfg_we,
    input  wire [1:0]  cfg_wdata
);

    // configuration
    logic [1:0] min_run_reg;

    // input register stage
    logic       s1_valid_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_eos_reg;

    // pending byte / run state, advanced once per item
    state_t     st_reg;
    state_t     st_next;

    // result burst: slot 0 faces dout, the rest shift down as bytes leave
    result_vec_t slots_reg;
    result_vec_t slots_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;

    result_vec_t step_res;
    logic [2:0]  step_cnt;

    logic din_take;
    logic out_take;
    logic buf_free;
    logic load;

    scrc_step u_step (
        .st            (st_reg),
        .ch            (s1_ch_reg),
        .end_of_string (s1_eos_reg),
        .min_run       (min_run_reg),
        .st_next       (st_next),
        .res           (step_res),
        .res_cnt       (step_cnt)
    );

    // burst register can take a new item's results when it is empty or empties this cycle
    assign out_take  = dout.valid && dout.ready;
    assign buf_free  = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && dout.ready);
    assign load      = s1_valid_reg && buf_free;
    assign din.ready = !s1_valid_reg || load;
    assign din_take  = din.valid && din.ready;

    assign dout.valid       = (cnt_reg != 3'd0);
    assign dout.out_char    = slots_reg[0].out_char;
    assign dout.last_of_run = slots_reg[0].last_of_run;
    assign dout.string_done = slots_reg[0].string_done;

    always_comb
    begin
        slots_next = slots_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            // an item with no result (first byte of a string, or a byte that continues a run) leaves the burst empty
            slots_next = step_res;
            cnt_next   = step_cnt;
        end
        else if (out_take)
        begin
            for (int i = 0; i < int'(MAX_RESULTS) - 1; i++)
                slots_next[i] = slots_reg[i+1];
            slots_next[MAX_RESULTS-1] = '0;
            cnt_next = cnt_reg - 3'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg  <= MIN_RUN_RESET;
            s1_valid_reg <= 1'b0;
            st_reg       <= '0;
            cnt_reg      <= 3'd0;
        end
        else
        begin
            if (cfg_we)
                min_run_reg <= cfg_wdata;
            if (din.ready)
                s1_valid_reg <= din.valid;
            if (load)
                st_reg <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (din_take)
        begin
            s1_ch_reg  <= din.ch;
            s1_eos_reg <= din.end_of_string;
        end
        slots_reg <= slots_next;
    end

endmodule

`default_nettype wire

### sv/scrc_checker.sv
`default_nettype none

`include "sequential_char_run_contractor_top_assert.svh"

module scrc_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       dout_valid,
    input wire       dout_ready,
    input wire [7:0] dout_out_char,
    input wire       dout_last_of_run,
    input wire       dout_string_done
);

    // a stalled result holds
    `SCRC_ASSERT_NEXT(a_out_hold, dout_valid && !dout_ready, dout_valid)
    `SCRC_ASSERT_NEXT(a_out_stable, dout_valid && !dout_ready, $stable(dout_out_char) && $stable(dout_last_of_run) && $stable(dout_string_done))

    // the end of a string is always the end of an item's burst
    `SCRC_ASSERT_NOW(a_done_is_last, dout_valid && dout_string_done, dout_last_of_run)

    // one item's burst leaves without gaps
    `SCRC_ASSERT_NEXT(a_burst_cont, dout_valid && dout_ready && !dout_last_of_run, dout_valid)

endmodule

bind sequential_char_run_contractor_top scrc_checker u_scrc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .dout_valid       (dout.valid),
    .dout_ready       (dout.ready),
    .dout_out_char    (dout.out_char),
    .dout_last_of_run (dout.last_of_run),
    .dout_string_done (dout.string_done)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the run contractor. Bytes go in as items on din; the contracted
// text comes back on dout, zero or more bytes per item. A predictor in this module tracks
// the held byte, the run head and the pair count, and queues the bytes that
// each accepted item should produce. A checker pops them in order.
module tb_top;
    import scrc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    // A burst of up to six result bytes drains one per cycle while the receiver takes them.
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 150;

    typedef enum logic [1:0] {CLS_NONE, CLS_LOWER, CLS_UPPER, CLS_DIGIT} char_class_e;
    typedef logic [7:0] byte_q_t[$];

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    scrc_in_if  din_bus();
    scrc_out_if dout_bus();

    sequential_char_run_contractor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_bus),
        .dout      (dout_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block's run tracking and its register.
    // ------------------------------------------------------------------
    logic [7:0] held_byte;      // byte still waiting for its successor
    logic       held_ok;
    logic [7:0] run_head;       // first byte of the run being tracked
    logic [1:0] seq_pairs;      // sequential pairs so far, saturates at 2
    logic [1:0] contract_len;   // shadow of min_run

    result_t    burst[$];           // bytes produced by the item being predicted
    result_t    expected_bytes[$];  // bytes still owed by the block, oldest first

    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          strings_sent;
    int unsigned cycle_count;
    bit          in_idle_en;    // sender draws random gaps
    bit          out_idle_en;   // receiver draws random stalls
    bit          out_hold;      // long receiver hold-off in progress

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic char_class_e class_of(logic [7:0] c);
        if (c >= "a" && c <= "z")
            return CLS_LOWER;
        if (c >= "A" && c <= "Z")
            return CLS_UPPER;
        if (c >= "0" && c <= "9")
            return CLS_DIGIT;
        return CLS_NONE;
    endfunction

    // True when nxt continues a run started at cur: same class, one greater.
    function automatic bit follows(logic [7:0] cur, logic [7:0] nxt);
        return class_of(cur) != CLS_NONE && class_of(cur) == class_of(nxt)
            && {1'b0, nxt} == {1'b0, cur} + 9'd1;
    endfunction

    function automatic void emit(logic [7:0] c);
        result_t r;
        r.out_char    = c;
        r.last_of_run = 1'b0;
        r.string_done = 1'b0;
        burst.push_back(r);
    endfunction

    // Decide the fate of one byte once its successor is known.
    function automatic void settle_byte(logic [7:0] cur, bit continues);
        logic [1:0] limit;
        limit = (contract_len < 2'd2) ? 2'd2 : contract_len;   // 0 and 1 act as 2
        if (continues)
        begin
            if (seq_pairs == 2'd0)
            begin
                run_head  = cur;
                seq_pairs = 2'd1;
            end
            else if (seq_pairs < 2'd2)
            begin
                seq_pairs = seq_pairs + 2'd1;
            end
        end
        else
        begin
            if (seq_pairs != 2'd0 && seq_pairs >= limit - 2'd1)
            begin
                emit(run_head);
                emit(DASH_CHAR);
                emit(cur);
            end
            else if (seq_pairs != 2'd0)
            begin
                emit(run_head);
                emit(cur);
            end
            else
            begin
                emit(cur);
            end
            seq_pairs = 2'd0;
        end
    endfunction

    function automatic void clear_run_state();
        held_byte = 8'd0;
        held_ok   = 1'b0;
        run_head  = 8'd0;
        seq_pairs = 2'd0;
    endfunction

    // Expected output for one accepted item, appended to expected_bytes.
    function automatic void predict_item(logic [7:0] c, logic eos);
        burst.delete();
        if (held_ok)
            settle_byte(held_byte, follows(held_byte, c));
        held_byte = c;
        held_ok   = 1'b1;
        if (eos)
        begin
            // final byte is judged against the terminator, which ends any run
            settle_byte(c, 1'b0);
            clear_run_state();
        end
        if (burst.size() > 0)
        begin
            burst[burst.size()-1].last_of_run = 1'b1;
            if (eos)
                burst[burst.size()-1].string_done = 1'b1;
        end
        foreach (burst[i])
            expected_bytes.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. valid stays high across back-to-back items; it is only
    // dropped when a gap is drawn or the sender stops.
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] c, logic eos);
        int gap;
        gap = in_idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            din_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_bus.valid         <= 1'b1;
        din_bus.ch            <= c;
        din_bus.end_of_string <= eos;
        @(posedge clk);
        while (!din_bus.ready)
            @(posedge clk);
        predict_item(c, eos);
        items_sent++;
    endtask

    // Sends bytes; the flag goes on the last one only when the string ends here.
    task automatic send_bytes(byte_q_t s, bit ends_string);
        foreach (s[i])
            send_byte(s[i], ends_string && (i == s.size() - 1));
        if (ends_string)
            strings_sent++;
    endtask

    // Stop offering items and wait until every owed byte has come back.
    task automatic wait_drained();
        din_bus.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while drained and at a string boundary.
    task automatic write_min_run(logic [1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        contract_len = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic byte_q_t text(string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Random text: mostly ascending runs inside one class, with printable and
    // arbitrary bytes mixed in to break runs.
    function automatic byte_q_t make_text(int len);
        byte_q_t    s;
        int         kind;
        int         run;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] c;
        while (s.size() < len)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                case ($urandom_range(0, 2))
                    0:       begin lo = "a"; hi = "z"; end
                    1:       begin lo = "A"; hi = "Z"; end
                    default: begin lo = "0"; hi = "9"; end
                endcase
                c   = 8'($urandom_range(lo, hi));
                run = $urandom_range(1, 5);
                while (run > 0 && s.size() < len && c <= hi)
                begin
                    s.push_back(c);
                    c = c + 8'd1;
                    run--;
                end
            end
            else if (kind <= 7)
            begin
                s.push_back(8'($urandom_range(32, 126)));
            end
            else
            begin
                s.push_back(8'($urandom_range(0, 255)));
            end
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: a random stall after each taken item, overridden by
    // the long hold-off flag.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        bit took;
        stall         = 0;
        dout_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            took = dout_bus.valid && dout_bus.ready;
            if (took)
                stall = out_idle_en ? $urandom_range(0, 7) : 0;
            else if (stall > 0)
                stall--;
            dout_bus.ready <= (stall == 0) && !out_hold;
        end
    end

    task automatic hold_output(int cycles);
        out_hold = 1'b1;
        repeat (cycles) @(negedge clk);
        out_hold = 1'b0;
    endtask

    task automatic report_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Result checker: each byte taken is matched against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            results_seen++;
            got.out_char    = dout_bus.out_char;
            got.last_of_run = dout_bus.last_of_run;
            got.string_done = dout_bus.string_done;
            if (expected_bytes.size() == 0)
            begin
                report_error($sformatf("unexpected byte %h last=%b done=%b",
                    got.out_char, got.last_of_run, got.string_done));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got.out_char !== want.out_char || got.last_of_run !== want.last_of_run
                    || got.string_done !== want.string_done)
                    report_error($sformatf(
                        "byte %0d: expected %h/%b/%b got %h/%b/%b (char/last/done)",
                        results_seen, want.out_char, want.last_of_run, want.string_done,
                        got.out_char, got.last_of_run, got.string_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value of min_run (3): long runs, short runs, class borders,
    // bytes outside every class, a one-byte string.
    task automatic test_default_setting();
        send_bytes(text("abcdx"), 1'b1);   // a-d then x, four bytes from one item
        send_bytes(text("yz{"), 1'b1);     // run stops at end of lowercase
        send_bytes(text("89:"), 1'b1);     // two-byte digit run stays as is
        send_bytes('{8'h00, 8'h80, 8'hFF}, 1'b1);
        send_bytes(text("Q"), 1'b1);
        wait_drained();
    endtask

    // Every register value: 2 contracts pairs, 0 and 1 behave as 2, 3 again.
    task automatic test_min_run_settings();
        write_min_run(2'd2);
        send_bytes(text("ab"), 1'b1);
        send_bytes(text("XYZ"), 1'b1);
        wait_drained();
        write_min_run(2'd0);
        send_bytes(text("mn"), 1'b1);
        wait_drained();
        write_min_run(2'd1);
        send_bytes(text("56"), 1'b1);
        wait_drained();
        write_min_run(2'd3);
        send_bytes(text("pq"), 1'b1);
        wait_drained();
    endtask

    // Random strings; register changes only at drained string boundaries.
    task automatic test_random_text(int n_items);
        int budget;
        int len;
        budget = n_items;
        while (budget > 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                wait_drained();
                write_min_run(2'($urandom_range(0, 3)));
            end
            // some strings run with no idling on either side
            in_idle_en  = $urandom_range(0, 3) != 0;
            out_idle_en = $urandom_range(0, 3) != 0;
            len = $urandom_range(1, 12);
            if (len > budget)
                len = budget;
            send_bytes(make_text(len), 1'b1);
            budget -= len;
        end
        wait_drained();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    // Receiver holds off while the sender pushes at full rate, so the block
    // fills and stalls intake.
    task automatic test_output_backpressure();
        in_idle_en = 1'b0;
        fork
            hold_output(HOLD_CYCLES);
        join_none
        repeat (4) send_bytes(make_text($urandom_range(8, 12)), 1'b1);
        wait_drained();
        in_idle_en = 1'b1;
    endtask

    // Sender pauses mid-string until everything owed has come back, then
    // finishes the string; the held byte must survive the pause.
    task automatic test_sender_pause();
        byte_q_t s;
        int      cut;
        repeat (5)
        begin
            s   = make_text($urandom_range(4, 10));
            cut = $urandom_range(1, s.size() - 1);
            send_bytes(s[0:cut-1], 1'b0);
            wait_drained();
            send_bytes(s[cut:s.size()-1], 1'b1);
        end
        wait_drained();
    endtask

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d bytes still owed",
            cycle_count, expected_bytes.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 2'd0;
        din_bus.valid         = 1'b0;
        din_bus.ch            = 8'd0;
        din_bus.end_of_string = 1'b0;
        in_idle_en            = 1'b1;
        out_idle_en           = 1'b1;
        out_hold              = 1'b0;
        mismatches            = 0;
        results_seen          = 0;
        items_sent            = 0;
        strings_sent          = 0;
        contract_len          = MIN_RUN_RESET;
        clear_run_state();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_setting();
        test_min_run_settings();
        test_random_text(300);
        test_output_backpressure();
        test_sender_pause();
        wait_drained();

        $display("Covered %0d items in %0d strings, %0d result bytes checked,",
            items_sent, strings_sent, results_seen);
        $display("min_run 0 to 3, a long output hold-off and mid-string sender pauses.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
